FILE: rtl/tcst_pkg.sv
package tcst_pkg;

    // Slot table size and derived widths
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // Queue between classifier and executor
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Event types
    localparam logic [15:0] TYPE_KEY = 16'h0001;
    localparam logic [15:0] TYPE_ABS = 16'h0003;
    localparam logic [15:0] TYPE_MSC = 16'h0004;

    // Event codes
    localparam logic [15:0] CODE_MT_SLOT       = 16'h002f;
    localparam logic [15:0] CODE_MT_TRACKING   = 16'h0039;
    localparam logic [15:0] CODE_MSC_TIMESTAMP = 16'h0005;
    localparam logic [15:0] CODE_TOUCH         = 16'h014a;
    localparam logic [15:0] CODE_TOOL_1        = 16'h0145;
    localparam logic [15:0] CODE_TOOL_2        = 16'h014d;
    localparam logic [15:0] CODE_TOOL_3        = 16'h014e;
    localparam logic [15:0] CODE_TOOL_4        = 16'h014f;

    localparam logic [31:0] RELEASE_ID = 32'hFFFF_FFFF;

    // Key mask bits: touch key, then the four tool keys
    localparam int KEY_W     = 5;
    localparam int KEY_TOUCH = 0;
    localparam int KEY_TOOL1 = 1;
    localparam int KEY_TOOL2 = 2;
    localparam int KEY_TOOL3 = 3;
    localparam int KEY_TOOL4 = 4;

    typedef enum logic [1:0] {
        OP_OTHER = 2'd0,
        OP_SLOT  = 2'd1,
        OP_TRACK = 2'd2,
        OP_KEY   = 2'd3
    } op_kind_t;

    // Classified event as carried from front to back
    typedef struct packed {
        op_kind_t              kind;
        logic                  is_stamp;
        logic                  slot_ok;
        logic [SLOT_W-1:0]     slot_num;
        logic                  release_id;
        logic [KEY_W-1:0]      key_mask;
        logic                  key_on;
    } op_t;

endpackage

FILE: rtl/touch_contact_segment_tracker.sv
// Each accepted item passes the classifier register, the queue and the output register
// in turn; a low out_ready holds them.
// Throughput: one item per cycle while out_ready is high.
// Reset (rst_n, asynchronous, active low): slot 0 selected, no contacts active,
// all key flags and the pending break cleared, queue and output register empty.
module touch_contact_segment_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          event_type,
    input  logic [15:0]          event_code,
    input  logic signed [31:0]   event_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 break_before,
    output logic                 break_after
);
    import tcst_pkg::*;

    logic front_valid, front_ready;
    op_t  front_op;
    logic q_valid, q_ready;
    op_t  q_op;

    // Classify incoming items
    tcst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .op_valid    (front_valid),
        .op_ready    (front_ready),
        .op          (front_op)
    );

    // Decouple front and back
    tcst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_op     (q_op)
    );

    // Track contacts and emit break flags
    tcst_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (q_valid),
        .op_ready     (q_ready),
        .op           (q_op),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .break_before (break_before),
        .break_after  (break_after)
    );

endmodule

FILE: rtl/tcst_front.sv
module tcst_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          event_type,
    input  logic [15:0]          event_code,
    input  logic signed [31:0]   event_value,
    output logic                 op_valid,
    input  logic                 op_ready,
    output tcst_pkg::op_t        op
);
    import tcst_pkg::*;

    logic        valid_reg;
    op_t         op_reg;
    op_t         op_next;
    logic [31:0] value_u;

    assign value_u  = $unsigned(event_value);
    assign in_ready = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    // Classify the incoming item
    always_comb
    begin
        op_next            = '0;
        op_next.kind       = OP_OTHER;
        op_next.is_stamp   = (event_type == TYPE_MSC) && (event_code == CODE_MSC_TIMESTAMP);
        op_next.slot_ok    = value_u < 32'(SLOTS);
        op_next.slot_num   = value_u[SLOT_W-1:0];
        op_next.release_id = value_u == RELEASE_ID;
        op_next.key_on     = |value_u;

        case (event_code)
            CODE_TOUCH:  op_next.key_mask[KEY_TOUCH] = 1'b1;
            CODE_TOOL_1: op_next.key_mask[KEY_TOOL1] = 1'b1;
            CODE_TOOL_2: op_next.key_mask[KEY_TOOL2] = 1'b1;
            CODE_TOOL_3: op_next.key_mask[KEY_TOOL3] = 1'b1;
            CODE_TOOL_4: op_next.key_mask[KEY_TOOL4] = 1'b1;
            default:     op_next.key_mask = '0;
        endcase

        if (event_type == TYPE_ABS && event_code == CODE_MT_SLOT)
        begin
            op_next.kind = OP_SLOT;
        end
        else if (event_type == TYPE_ABS && event_code == CODE_MT_TRACKING)
        begin
            op_next.kind = OP_TRACK;
        end
        else if (event_type == TYPE_KEY && (|op_next.key_mask))
        begin
            op_next.kind = OP_KEY;
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= op_next;
        end
    end

endmodule

FILE: rtl/tcst_queue.sv
module tcst_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  tcst_pkg::op_t    push_op,
    output logic             pop_valid,
    input  logic             pop_ready,
    output tcst_pkg::op_t    pop_op
);
    import tcst_pkg::*;

    op_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: rtl/tcst_back.sv
module tcst_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_ready,
    input  tcst_pkg::op_t    op,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             break_before,
    output logic             break_after
);
    import tcst_pkg::*;

    logic [SLOT_W-1:0] slot_index_reg, slot_index_next;
    logic              slot_valid_reg, slot_valid_next;
    logic [SLOTS-1:0]  slot_active_reg, slot_active_next;
    logic [CNT_W-1:0]  active_count_reg, active_count_next;
    logic              touch_key_reg, touch_key_next;
    logic [3:0]        tool_flags_reg, tool_flags_next;
    logic              pending_reg, pending_next;
    logic              out_valid_reg;
    logic              before_reg, before_next;
    logic              after_reg, after_next;

    logic              pop;
    logic              cur_active;
    logic [KEY_W-1:0]  keys_cur, keys_new;
    logic              prev_touching, now_touching;
    logic              pend_mid;

    assign op_ready     = !out_valid_reg || out_ready;
    assign pop          = op_valid && op_ready;
    assign out_valid    = out_valid_reg;
    assign break_before = before_reg;
    assign break_after  = after_reg;

    assign cur_active = slot_active_reg[slot_index_reg];
    assign keys_cur   = {tool_flags_reg, touch_key_reg};

    // Apply one item to the tracking state
    always_comb
    begin
        slot_index_next   = slot_index_reg;
        slot_valid_next   = slot_valid_reg;
        slot_active_next  = slot_active_reg;
        active_count_next = active_count_reg;
        keys_new          = keys_cur;

        case (op.kind)
            OP_SLOT:
            begin
                slot_valid_next = op.slot_ok;
                if (op.slot_ok)
                begin
                    slot_index_next = op.slot_num;
                end
            end
            OP_TRACK:
            begin
                if (slot_valid_reg)
                begin
                    if (op.release_id && cur_active)
                    begin
                        slot_active_next[slot_index_reg] = 1'b0;
                        active_count_next = active_count_reg - 1'b1;
                    end
                    else if (!op.release_id && !cur_active)
                    begin
                        slot_active_next[slot_index_reg] = 1'b1;
                        active_count_next = active_count_reg + 1'b1;
                    end
                end
            end
            OP_KEY:
            begin
                keys_new = op.key_on ? (keys_cur | op.key_mask) : (keys_cur & ~op.key_mask);
            end
            default:
            begin
                keys_new = keys_cur;
            end
        endcase

        touch_key_next  = keys_new[KEY_TOUCH];
        tool_flags_next = keys_new[KEY_TOOL4:KEY_TOOL1];

        // Break bookkeeping around the update
        prev_touching = (active_count_reg != '0) || (|keys_cur);
        now_touching  = (active_count_next != '0) || (|keys_new);
        before_next   = pending_reg && !op.is_stamp;
        pend_mid      = before_next ? 1'b0 : pending_reg;
        if (prev_touching && !now_touching)
        begin
            pend_mid = 1'b1;
        end
        after_next   = pend_mid && op.is_stamp;
        pending_next = after_next ? 1'b0 : pend_mid;
    end

    // Tracking state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_index_reg   <= '0;
            slot_valid_reg   <= 1'b1;
            slot_active_reg  <= '0;
            active_count_reg <= '0;
            touch_key_reg    <= 1'b0;
            tool_flags_reg   <= '0;
            pending_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            before_reg       <= 1'b0;
            after_reg        <= 1'b0;
        end
        else
        begin
            if (op_ready)
            begin
                out_valid_reg <= op_valid;
            end
            if (pop)
            begin
                slot_index_reg   <= slot_index_next;
                slot_valid_reg   <= slot_valid_next;
                slot_active_reg  <= slot_active_next;
                active_count_reg <= active_count_next;
                touch_key_reg    <= touch_key_next;
                tool_flags_reg   <= tool_flags_next;
                pending_reg      <= pending_next;
                before_reg       <= before_next;
                after_reg        <= after_next;
            end
        end
    end

`ifndef SYNTHESIS
    // Contact count follows the active bitmap
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        active_count_reg == CNT_W'($countones(slot_active_reg)))
        else $error("active count out of step with slot bitmap");

    // A result never marks a break on both sides
    a_one_break: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(before_reg && after_reg))
        else $error("break marked before and after one item");

    // A timestamp item always drains the pending break
    a_stamp_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && op.is_stamp) |=> !pending_reg)
        else $error("break still pending after timestamp");
`endif

endmodule
